>>> rtl/core/isc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isc_pkg
// shared types and codes of the itemset support counter
// ----------------------------------------------------------------------------
package isc_pkg;

    // operation codes on the func field
    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_ROW    = 2'd1;
    localparam logic [1:0] FUNC_REPORT = 2'd2;

    // fixed field widths
    localparam int FUNC_W    = 2;
    localparam int BITS_W    = 32;
    localparam int INDEX_W   = 5;
    localparam int SUPPORT_W = 20;
    localparam int MINSUP_W  = 20;

    // report sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_REPORT
    } isc_state_t;

    // broadcast control to every cell of the chain
    typedef struct packed {
        logic load;
        logic row;
        logic shift;
    } isc_cell_ctrl_t;

endpackage : isc_pkg
`default_nettype wire

>>> rtl/core/isc_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isc_cell
// one candidate slot: item mask and saturating support counter, which hands
// its count to the lower neighbor while a report drains the chain
// ----------------------------------------------------------------------------
module isc_cell #(
    parameter int ITEM_W  = 32,
    parameter int COUNT_W = 20
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  isc_pkg::isc_cell_ctrl_t  ctrl,
    input  wire                      sel,
    input  wire                      occupied,
    input  wire  [ITEM_W-1:0]        row_bits,
    input  wire  [COUNT_W-1:0]       count_in,
    output logic [COUNT_W-1:0]       count
);
    import isc_pkg::*;

    logic [ITEM_W-1:0]  mask_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               hit;

    // candidate contained in the row and counter not saturated
    assign hit = ((row_bits & mask_reg) == mask_reg) && !(&count_reg);

    // mask store, written only on a load
    always_ff @(posedge clk)
    begin
        if (ctrl.load && sel)
        begin
            mask_reg <= row_bits;
        end
    end

    // support counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            count_reg <= count_in;
        end
        else if (ctrl.load && sel)
        begin
            count_reg <= '0;
        end
        else if (ctrl.row && occupied && hit)
        begin
            count_reg <= count_reg + COUNT_W'(1);
        end
    end

    assign count = count_reg;

endmodule : isc_cell
`default_nettype wire

>>> rtl/core/itemset_support_counter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itemset_support_counter_unit
// apriori support counting over a chain of candidate cells
// ----------------------------------------------------------------------------
// Candidate loads and transaction rows are accepted while no report runs:
// every occupied cell compares the row against its own mask in parallel and
// bumps its counter on a hit. A report is drained through the cell chain,
// one candidate per cycle out of cell 0 while the output is not stalled, as
// the others shift down; no input beat is taken during a report. The last
// result of a report clears the table and the overflow flag.
// ----------------------------------------------------------------------------
module itemset_support_counter_unit #(
    parameter int NUM_ITEMS      = 32,
    parameter int MAX_CANDIDATES = 32,
    parameter int COUNT_BITS     = 20
) (
    input  wire                              clk,
    input  wire                              rst_n,
    // configuration
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [isc_pkg::MINSUP_W-1:0]     cfg_data,
    // input channel
    input  wire                              in_valid,
    output logic                             in_stall,
    input  wire  [isc_pkg::FUNC_W-1:0]       func,
    input  wire  [isc_pkg::BITS_W-1:0]       item_bits,
    // result channel
    output logic                             out_valid,
    input  wire                              out_stall,
    output logic [isc_pkg::INDEX_W-1:0]      candidate_index,
    output logic [isc_pkg::SUPPORT_W-1:0]    support,
    output logic                             frequent,
    output logic                             valid_res,
    output logic                             overflow,
    output logic                             last
);
    import isc_pkg::*;

    localparam int ITEM_W = (NUM_ITEMS > BITS_W) ? BITS_W : NUM_ITEMS;
    localparam int TOT_W  = $clog2(MAX_CANDIDATES + 1);
    localparam int IDX_W  = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
    localparam int XIDX_W = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;
    localparam int CMP_W  = (COUNT_BITS > SUPPORT_W) ? COUNT_BITS : SUPPORT_W;

    isc_state_t           state_reg, state_next;
    logic [TOT_W-1:0]     total_reg, total_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 dropped_reg, dropped_next;
    logic [MINSUP_W-1:0]  minsup_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]   index_reg, index_next;
    logic [SUPPORT_W-1:0] support_reg, support_next;
    logic                 frequent_reg, frequent_next;
    logic                 valid_res_reg, valid_res_next;
    logic                 overflow_reg, overflow_next;
    logic                 last_reg, last_next;

    logic                 in_accept;
    logic                 slot_free;
    logic [ITEM_W-1:0]    row_bits;
    isc_cell_ctrl_t       ctrl;
    wire  [COUNT_BITS-1:0] chain [0:MAX_CANDIDATES];
    logic [CMP_W-1:0]     head_ext;
    logic [XIDX_W-1:0]    idx_ext;
    logic                 is_last;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign row_bits  = item_bits[ITEM_W-1:0];
    assign cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            minsup_reg <= MINSUP_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            minsup_reg <= cfg_data;
        end
    end

    // chain of candidate cells, zero shifted in at the top end
    assign chain[MAX_CANDIDATES] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_CANDIDATES; gi++)
        begin : g_cell
            isc_cell #(
                .ITEM_W  (ITEM_W),
                .COUNT_W (COUNT_BITS)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .sel      (total_reg == TOT_W'(gi)),
                .occupied (total_reg > TOT_W'(gi)),
                .row_bits (row_bits),
                .count_in (chain[gi+1]),
                .count    (chain[gi])
            );
        end
    endgenerate

    // head of the chain as a result
    assign head_ext = CMP_W'(chain[0]);
    assign idx_ext  = XIDX_W'(idx_reg);
    assign is_last  = (TOT_W'(idx_reg) + TOT_W'(1)) == total_reg;

    // sequencer next state and result
    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        idx_next       = idx_reg;
        dropped_next   = dropped_reg;
        ctrl           = '0;
        out_valid_next = out_valid_reg && out_stall;
        index_next     = index_reg;
        support_next   = support_reg;
        frequent_next  = frequent_reg;
        valid_res_next = valid_res_reg;
        overflow_next  = overflow_reg;
        last_next      = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (func)
                        FUNC_LOAD:
                        begin
                            if (total_reg < TOT_W'(MAX_CANDIDATES))
                            begin
                                ctrl.load  = 1'b1;
                                total_next = total_reg + TOT_W'(1);
                            end
                            else
                            begin
                                dropped_next = 1'b1;
                            end
                        end
                        FUNC_ROW:
                        begin
                            ctrl.row = 1'b1;
                        end
                        FUNC_REPORT:
                        begin
                            idx_next   = '0;
                            state_next = ST_REPORT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_REPORT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    overflow_next  = dropped_reg;
                    if (total_reg == '0)
                    begin
                        index_next     = '0;
                        support_next   = '0;
                        frequent_next  = 1'b0;
                        valid_res_next = 1'b0;
                        last_next      = 1'b1;
                    end
                    else
                    begin
                        ctrl.shift     = 1'b1;
                        index_next     = idx_ext[INDEX_W-1:0];
                        support_next   = head_ext[SUPPORT_W-1:0];
                        frequent_next  = head_ext >= CMP_W'(minsup_reg);
                        valid_res_next = 1'b1;
                        last_next      = is_last;
                        idx_next       = idx_reg + IDX_W'(1);
                    end
                    if (total_reg == '0 || is_last)
                    begin
                        total_next   = '0;
                        dropped_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            idx_reg       <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            idx_reg       <= idx_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        index_reg     <= index_next;
        support_reg   <= support_next;
        frequent_reg  <= frequent_next;
        valid_res_reg <= valid_res_next;
        overflow_reg  <= overflow_next;
        last_reg      <= last_next;
    end

    assign out_valid       = out_valid_reg;
    assign candidate_index = index_reg;
    assign support         = support_reg;
    assign frequent        = frequent_reg;
    assign valid_res       = valid_res_reg;
    assign overflow        = overflow_reg;
    assign last            = last_reg;

endmodule : itemset_support_counter_unit
`default_nettype wire

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the itemset support counter: a directed table, then
// random load/row/report runs under several idle and stall mixes, and a long
// output hold that backs up the input
// ----------------------------------------------------------------------------
module tb;
    import isc_pkg::*;

    // the func encoding the block must ignore
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam int TABLE_DEPTH    = 32;
    localparam int DIR_N          = 22;
    localparam int RAND_PER_PHASE = 72;
    localparam int SETTLE_CYCLES  = 6;
    localparam int DRAIN_LIMIT    = 100000;
    localparam int HOLD_CYCLES    = 300;
    localparam int CYCLE_LIMIT    = 200000;

    typedef struct packed {
        logic [INDEX_W-1:0]   idx;
        logic [SUPPORT_W-1:0] sup;
        logic                 freq;
        logic                 vres;
        logic                 ovf;
        logic                 is_last;
    } support_rec_t;

    typedef struct packed {
        logic [FUNC_W-1:0] op;
        logic [BITS_W-1:0] bits;
        logic              typed;
        support_rec_t      want;
    } stim_row_t;

    localparam support_rec_t NO_REC       = '0;
    localparam support_rec_t EMPTY_REPORT = {5'd0, 20'd0, 1'b0, 1'b0, 1'b0, 1'b1};

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [MINSUP_W-1:0]  cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [FUNC_W-1:0]    func = FUNC_LOAD;
    logic [BITS_W-1:0]    item_bits = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [INDEX_W-1:0]   candidate_index;
    logic [SUPPORT_W-1:0] support;
    logic                 frequent;
    logic                 valid_res;
    logic                 overflow;
    logic                 last;

    // predictor copy of the candidate table and the threshold
    logic [BITS_W-1:0]    cand_mask [TABLE_DEPTH];
    logic [SUPPORT_W-1:0] cand_count [TABLE_DEPTH];
    int                   cand_total = 0;
    logic                 cand_dropped = 1'b0;
    logic [MINSUP_W-1:0]  min_support = 20'd1;

    support_rec_t support_due [$];
    stim_row_t    dir_tab [DIR_N];

    int mismatches = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    itemset_support_counter_unit DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (func),
        .item_bits       (item_bits),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .candidate_index (candidate_index),
        .support         (support),
        .frequent        (frequent),
        .valid_res       (valid_res),
        .overflow        (overflow),
        .last            (last)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver stall: random, or a long hold when one is requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_seen <= 0;
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // update the predicted table for one accepted beat, queue any report
    task automatic tally_support(input logic [FUNC_W-1:0] op, input logic [BITS_W-1:0] bits);
        support_rec_t rec;
        case (op)
            FUNC_LOAD:
            begin
                if (cand_total < TABLE_DEPTH)
                begin
                    cand_mask[cand_total]  = bits;
                    cand_count[cand_total] = '0;
                    cand_total++;
                end
                else
                begin
                    cand_dropped = 1'b1;
                end
            end
            FUNC_ROW:
            begin
                for (int i = 0; i < cand_total; i++)
                begin
                    if ((bits & cand_mask[i]) == cand_mask[i] && cand_count[i] != '1)
                        cand_count[i]++;
                end
            end
            FUNC_REPORT:
            begin
                if (cand_total == 0)
                begin
                    rec = EMPTY_REPORT;
                    rec.ovf = cand_dropped;
                    support_due.push_back(rec);
                end
                else
                begin
                    for (int i = 0; i < cand_total; i++)
                    begin
                        rec.idx     = i[INDEX_W-1:0];
                        rec.sup     = cand_count[i];
                        rec.freq    = (cand_count[i] >= min_support);
                        rec.vres    = 1'b1;
                        rec.ovf     = cand_dropped;
                        rec.is_last = (i == cand_total - 1);
                        support_due.push_back(rec);
                    end
                end
                cand_total   = 0;
                cand_dropped = 1'b0;
            end
            default:
            begin
            end
        endcase
    endtask

    // offer one beat, with random idle cycles ahead of it
    task automatic send_beat(input logic [FUNC_W-1:0] op, input logic [BITS_W-1:0] bits);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        func      <= op;
        item_bits <= bits;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tally_support(op, bits);
    endtask

    // threshold write, only while the block is idle
    task automatic write_min_support(input logic [MINSUP_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        min_support = value;
        cfg_valid <= 1'b0;
    endtask

    // stop sending and wait for every queued report beat
    task automatic wait_drain();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (support_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // sparse masks so that rows support them now and then
    function automatic logic [BITS_W-1:0] rand_mask();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return $urandom & $urandom & $urandom;
        endcase
    endfunction

    function automatic logic [BITS_W-1:0] rand_row(input logic [BITS_W-1:0] mask);
        case ($urandom_range(7))
            0: return '1;
            1: return '0;
            2, 3: return mask | $urandom;
            default: return $urandom | $urandom;
        endcase
    endfunction

    // result channel check against the oldest expectation
    always @(posedge clk)
    begin : result_check
        support_rec_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (support_due.size() == 0)
            begin
                $display("%0t: unexpected result, index %0d support %0h", $time,
                         candidate_index, support);
                mismatches++;
            end
            else
            begin
                want = support_due.pop_front();
                check_field("candidate_index", 32'(want.idx), 32'(candidate_index));
                check_field("support", 32'(want.sup), 32'(support));
                check_field("frequent", 32'(want.freq), 32'(frequent));
                check_field("valid_res", 32'(want.vres), 32'(valid_res));
                check_field("overflow", 32'(want.ovf), 32'(overflow));
                check_field("last", 32'(want.is_last), 32'(last));
            end
        end
    end

    initial
    begin : stimulus
        int placed;
        int n_load;
        int n_row;
        logic [BITS_W-1:0]   mask;
        logic [FUNC_W-1:0]   op;
        logic [MINSUP_W-1:0] min_val;

        // directed table; typed results where they are obvious
        dir_tab[0]  = {FUNC_REPORT, 32'h0000_0000, 1'b1, EMPTY_REPORT};
        dir_tab[1]  = {FUNC_LOAD,   32'h0000_0000, 1'b0, NO_REC};
        dir_tab[2]  = {FUNC_ROW,    32'h0000_0000, 1'b0, NO_REC};
        dir_tab[3]  = {FUNC_ROW,    32'hFFFF_FFFF, 1'b0, NO_REC};
        dir_tab[4]  = {FUNC_REPORT, 32'hFFFF_FFFF, 1'b1,
                       support_rec_t'({5'd0, 20'd2, 1'b1, 1'b1, 1'b0, 1'b1})};
        dir_tab[5]  = {FUNC_UNUSED, 32'hFFFF_FFFF, 1'b0, NO_REC};
        dir_tab[6]  = {FUNC_LOAD,   32'hFFFF_FFFF, 1'b0, NO_REC};
        dir_tab[7]  = {FUNC_LOAD,   32'h0000_0001, 1'b0, NO_REC};
        dir_tab[8]  = {FUNC_LOAD,   32'h8000_0000, 1'b0, NO_REC};
        dir_tab[9]  = {FUNC_LOAD,   32'h0000_0000, 1'b0, NO_REC};
        dir_tab[10] = {FUNC_UNUSED, 32'h0000_0000, 1'b0, NO_REC};
        dir_tab[11] = {FUNC_ROW,    32'hFFFF_FFFF, 1'b0, NO_REC};
        dir_tab[12] = {FUNC_ROW,    32'h0000_0001, 1'b0, NO_REC};
        dir_tab[13] = {FUNC_ROW,    32'h8000_0000, 1'b0, NO_REC};
        dir_tab[14] = {FUNC_ROW,    32'h0000_0000, 1'b0, NO_REC};
        dir_tab[15] = {FUNC_LOAD,   32'hAAAA_AAAA, 1'b0, NO_REC};
        dir_tab[16] = {FUNC_ROW,    32'h5555_5555, 1'b0, NO_REC};
        dir_tab[17] = {FUNC_ROW,    32'hAAAA_AAAA, 1'b0, NO_REC};
        dir_tab[18] = {FUNC_REPORT, 32'h0000_0000, 1'b0, NO_REC};
        dir_tab[19] = {FUNC_LOAD,   32'h5555_5555, 1'b0, NO_REC};
        dir_tab[20] = {FUNC_REPORT, 32'h1234_5678, 1'b1,
                       support_rec_t'({5'd0, 20'd0, 1'b0, 1'b1, 1'b0, 1'b1})};
        dir_tab[21] = {FUNC_REPORT, 32'h0000_0000, 1'b1, EMPTY_REPORT};

        // reset
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset threshold
        for (int i = 0; i < DIR_N; i++)
        begin
            send_beat(dir_tab[i].op, dir_tab[i].bits);
            if (dir_tab[i].typed)
            begin
                void'(support_due.pop_back());
                support_due.push_back(dir_tab[i].want);
            end
        end
        wait_drain();

        // random load/row/report runs under each idle mix
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 0;  min_val = 20'd3;
                end
                1:
                begin
                    send_idle_pct = 66; recv_stall_pct = 0;  min_val = 20'd0;
                end
                2:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 66;
                    min_val = MINSUP_W'($urandom_range(1, 6));
                end
                default:
                begin
                    send_idle_pct = 18; recv_stall_pct = 18;
                    min_val = MINSUP_W'($urandom_range(0, 20'hFFFFF));
                end
            endcase
            write_min_support(min_val);
            placed = 0;
            while (placed < RAND_PER_PHASE)
            begin
                if ($urandom_range(99) < 85)
                begin
                    // well-formed run, sometimes past the table capacity
                    n_load = ($urandom_range(9) == 0) ? $urandom_range(28, 36)
                                                      : $urandom_range(1, 8);
                    n_row  = $urandom_range(0, 12);
                    mask   = '0;
                    for (int k = 0; k < n_load; k++)
                    begin
                        mask = rand_mask();
                        send_beat(FUNC_LOAD, mask);
                    end
                    for (int k = 0; k < n_row; k++)
                        send_beat(FUNC_ROW, rand_row(mask));
                    send_beat(FUNC_REPORT, $urandom);
                    placed += n_load + n_row + 1;
                end
                else
                begin
                    // stray beat of any kind
                    op = FUNC_W'($urandom_range(0, 3));
                    send_beat(op, $urandom);
                    if (op != FUNC_UNUSED)
                        placed++;
                end
            end
            wait_drain();
        end

        // long output hold while reports keep arriving, so the input backs up
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req <= hold_req + 1;
        for (int k = 0; k < 10; k++)
            send_beat(FUNC_LOAD, rand_mask());
        for (int k = 0; k < 3; k++)
            send_beat(FUNC_ROW, $urandom | $urandom);
        send_beat(FUNC_REPORT, $urandom);
        for (int k = 0; k < 6; k++)
            send_beat(FUNC_LOAD, rand_mask());
        send_beat(FUNC_ROW, '1);
        send_beat(FUNC_REPORT, $urandom);
        send_beat(FUNC_REPORT, $urandom);
        for (int k = 0; k < 3; k++)
            send_beat(FUNC_LOAD, rand_mask());
        send_beat(FUNC_REPORT, $urandom);
        wait_drain();

        // anything still queued never arrived
        if (support_due.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, support_due.size());
            mismatches += support_due.size();
        end
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
